@@ hdl/ivm_pkg.sv @@
// Shared types and codes for the interval value map.
`timescale 1ns / 1ps
package ivm_pkg;

  // request kinds on in_tuser
  localparam logic REQ_ASSIGN = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // result status codes on out_tuser
  localparam logic [1:0] STAT_LOOKUP = 2'd0;
  localparam logic [1:0] STAT_ASSIGN = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_FULL   = 2'd3;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_VSCAN   = 8'b0000_0010,
    ST_BLO     = 8'b0000_0100,
    ST_PLACE_B = 8'b0000_1000,
    ST_PLACE_E = 8'b0001_0000,
    ST_BHI     = 8'b0010_0000,
    ST_FIN     = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } st_t;

endpackage

@@ hdl/interval_value_map.sv @@
// Interval value map top level: request sequencer over a breakpoint table.
//
// channel | direction | contents
// in_     | slave     | tuser req_type; tdata key_begin, key_end, new_value, lookup_key
// out_    | master    | tuser status; tdata read_value
// cfg_    | slave     | cfg_data initial_value, always ready
//
// Lookup: a value scan over the stored breakpoints. Assign: a value scan for the value
// at key_end, then a rebuild pass into the spare bank, both paced by the single read
// port of the table (one entry per cycle). An empty range goes straight to the result.
// Reset empties the table; no clearing pass is needed. in_tready is low from acceptance
// until the result is loaded into the output register; a stalled output holds the
// sequencer in its last state.
`timescale 1ns / 1ps
module interval_value_map
  import ivm_pkg::*;
#(
  parameter int ENTRIES     = 32,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 8,
  localparam int IN_DW  = ((3 * KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   in_tuser,  // [0] req_type
  // key_begin, key_end, new_value, lookup_key from bit 0 up
  input  logic [IN_DW-1:0]       in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [1:0]             out_tuser, // [1:0] status
  output logic [OUT_DW-1:0]      out_tdata, // read_value
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [VALUE_WIDTH-1:0] cfg_data   // initial_value
);

  localparam int KW = KEY_WIDTH;
  localparam int VW = VALUE_WIDTH;
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int MW = $clog2(ENTRIES + 3);

  st_t            st_r, st_nxt;
  logic [VW-1:0]  init_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  rd_idx_r, rd_idx_nxt;
  logic           dv_r, dv_nxt;
  logic [CW-1:0]  dv_idx_r, dv_idx_nxt;
  logic           type_r;
  logic [KW-1:0]  kb_r, ke_r, lk_r;
  logic [VW-1:0]  nv_r;
  logic [VW-1:0]  acc_r, acc_nxt;
  logic [VW-1:0]  prev_r, prev_nxt;
  logic [MW-1:0]  m_r, m_nxt;
  logic [VW-1:0]  res_val_r, res_val_nxt;
  logic [1:0]     res_stat_r, res_stat_nxt;
  logic           out_valid_r;
  logic [VW-1:0]  out_val_r;
  logic [1:0]     out_stat_r;

  logic           rd_en, wr_en, swap;
  logic [KW-1:0]  rd_key, wr_key, scan_key;
  logic [VW-1:0]  rd_val, wr_val;
  logic           emit;
  logic [KW-1:0]  emit_key;
  logic [VW-1:0]  emit_val;
  logic           in_xfer, scan_end;
  logic [KW-1:0]  in_kb, in_ke, in_lk;
  logic [VW-1:0]  in_nv;

  assign in_kb = in_tdata[KW-1:0];
  assign in_ke = in_tdata[2*KW-1:KW];
  assign in_nv = in_tdata[2*KW+VW-1:2*KW];
  assign in_lk = in_tdata[3*KW+VW-1:2*KW+VW];

  assign in_tready  = (st_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = OUT_DW'(out_val_r);
  assign scan_key   = (type_r == REQ_LOOKUP) ? lk_r : ke_r;
  assign scan_end   = !dv_r && (rd_idx_r == count_r);

  ivm_table #(
    .ENTRIES    (ENTRIES),
    .KEY_WIDTH  (KW),
    .VALUE_WIDTH(VW)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (rd_en),
    .rd_idx(rd_idx_r[IW-1:0]),
    .wr_en (wr_en),
    .wr_idx(m_r[IW-1:0]),
    .wr_key(wr_key),
    .wr_val(wr_val),
    .swap  (swap),
    .rd_key(rd_key),
    .rd_val(rd_val)
  );

  // merge filter on the rebuilt list: drop entries repeating the value below or past the table
  assign wr_key = emit_key;
  assign wr_val = emit_val;
  assign wr_en  = emit && (emit_val != prev_r) && (m_r < MW'(ENTRIES));

  // sequencer
  always_comb begin
    st_nxt       = st_r;
    count_nxt    = count_r;
    rd_idx_nxt   = rd_idx_r;
    dv_nxt       = 1'b0;
    dv_idx_nxt   = dv_idx_r;
    acc_nxt      = acc_r;
    prev_nxt     = prev_r;
    m_nxt        = m_r;
    res_val_nxt  = res_val_r;
    res_stat_nxt = res_stat_r;
    rd_en        = 1'b0;
    swap         = 1'b0;
    emit         = 1'b0;
    emit_key     = rd_key;
    emit_val     = rd_val;

    // pipelined read issue during scans
    if ((st_r == ST_VSCAN || st_r == ST_BLO || st_r == ST_BHI) && rd_idx_r < count_r) begin
      rd_en      = 1'b1;
      rd_idx_nxt = rd_idx_r + CW'(1);
      dv_nxt     = 1'b1;
      dv_idx_nxt = rd_idx_r;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_xfer) begin
          rd_idx_nxt = '0;
          acc_nxt    = init_r;
          if (in_tuser == REQ_ASSIGN && !($signed(in_kb) < $signed(in_ke))) begin
            res_val_nxt  = '0;
            res_stat_nxt = STAT_EMPTY;
            st_nxt       = ST_DONE;
          end else begin
            st_nxt = ST_VSCAN;
          end
        end
      end
      ST_VSCAN: begin
        // last breakpoint at or below the key wins
        if (dv_r && $signed(rd_key) <= $signed(scan_key)) begin
          acc_nxt = rd_val;
        end
        if (scan_end) begin
          if (type_r == REQ_LOOKUP) begin
            res_val_nxt  = acc_r;
            res_stat_nxt = STAT_LOOKUP;
            st_nxt       = ST_DONE;
          end else begin
            rd_idx_nxt = '0;
            prev_nxt   = init_r;
            m_nxt      = '0;
            st_nxt     = ST_BLO;
          end
        end
      end
      ST_BLO: begin
        // copy breakpoints below key_begin
        if (dv_r) begin
          if ($signed(rd_key) < $signed(kb_r)) begin
            emit = 1'b1;
          end else begin
            rd_idx_nxt = dv_idx_r;
            dv_nxt     = 1'b0;
            rd_en      = 1'b0;
            st_nxt     = ST_PLACE_B;
          end
        end else if (scan_end) begin
          st_nxt = ST_PLACE_B;
        end
      end
      ST_PLACE_B: begin
        emit     = 1'b1;
        emit_key = kb_r;
        emit_val = nv_r;
        st_nxt   = ST_PLACE_E;
      end
      ST_PLACE_E: begin
        emit     = 1'b1;
        emit_key = ke_r;
        emit_val = acc_r;
        st_nxt   = ST_BHI;
      end
      ST_BHI: begin
        // copy breakpoints above key_end
        if (dv_r && $signed(rd_key) > $signed(ke_r)) begin
          emit = 1'b1;
        end
        if (scan_end) begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        res_val_nxt = '0;
        if (m_r > MW'(ENTRIES)) begin
          res_stat_nxt = STAT_FULL;
        end else begin
          swap         = 1'b1;
          count_nxt    = CW'(m_r);
          res_stat_nxt = STAT_ASSIGN;
        end
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (emit && emit_val != prev_r) begin
      m_nxt    = m_r + MW'(1);
      prev_nxt = emit_val;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      dv_r        <= 1'b0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      dv_r    <= dv_nxt;
      if (cfg_valid && cfg_ready) begin
        init_r <= cfg_data;
      end
      if (st_r == ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    dv_idx_r   <= dv_idx_nxt;
    acc_r      <= acc_nxt;
    prev_r     <= prev_nxt;
    m_r        <= m_nxt;
    res_val_r  <= res_val_nxt;
    res_stat_r <= res_stat_nxt;
    if (in_xfer) begin
      type_r <= in_tuser;
      kb_r   <= in_kb;
      ke_r   <= in_ke;
      nv_r   <= in_nv;
      lk_r   <= in_lk;
    end
    if (st_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_val_r  <= res_val_r;
      out_stat_r <= res_stat_r;
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("breakpoint count above table size");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("new request taken while one is in progress");

  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN && m_r > MW'(ENTRIES)) |=> $stable(count_r))
    else $error("rejected assign changed the table");

endmodule

@@ hdl/ivm_table.sv @@
// Ping-pong breakpoint memory: read the live bank, rebuild into the spare bank.
`timescale 1ns / 1ps
module ivm_table #(
  parameter int ENTRIES     = 32,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 8,
  localparam int IW = $clog2(ENTRIES)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [IW-1:0]          rd_idx,
  input  logic                   wr_en,
  input  logic [IW-1:0]          wr_idx,
  input  logic [KEY_WIDTH-1:0]   wr_key,
  input  logic [VALUE_WIDTH-1:0] wr_val,
  input  logic                   swap,
  output logic [KEY_WIDTH-1:0]   rd_key,
  output logic [VALUE_WIDTH-1:0] rd_val
);

  localparam int DEPTH = 2 << IW;

  logic [KEY_WIDTH-1:0]   mem_key [DEPTH];
  logic [VALUE_WIDTH-1:0] mem_val [DEPTH];
  logic                   bank_r;

  // live bank select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
    end else if (swap) begin
      bank_r <= ~bank_r;
    end
  end

  // spare bank write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[{~bank_r, wr_idx}] <= wr_key;
      mem_val[{~bank_r, wr_idx}] <= wr_val;
    end
  end

  // live bank registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= mem_key[{bank_r, rd_idx}];
      rd_val <= mem_val[{bank_r, rd_idx}];
    end
  end

endmodule

@@ sim/tb_interval_value_map.sv @@
// Self-checking testbench for the interval value map: assign and lookup traffic.
`timescale 1ns / 1ps
module tb_interval_value_map;
  import ivm_pkg::*;

  localparam int ENTRIES = 32;
  localparam int IN_DW   = 56;
  localparam int OUT_DW  = 8;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] kb;
    logic signed [15:0] ke;
    logic [7:0]        val;
    logic signed [15:0] lk;
  } req_t;

  typedef struct packed {
    logic [7:0] rd;
    logic [1:0] st;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic in_tuser = 1'b0;
  logic [IN_DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [1:0] out_tuser;
  logic [OUT_DW-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  interval_value_map dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // shadow copy of the breakpoint table
  logic signed [15:0] bp_key[ENTRIES];
  logic [7:0]         bp_val[ENTRIES];
  int                 bp_count;
  logic [7:0]         init_val;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   err_count;
  int   rsp_seen;
  int   n_assign, n_full, n_empty;
  int   send_idle_pct, recv_stall_pct;

  function automatic logic [7:0] value_at_key(logic signed [15:0] k);
    logic [7:0] v;
    v = init_val;
    for (int i = 0; i < bp_count; i++) begin
      if (bp_key[i] <= k) v = bp_val[i];
      else break;
    end
    return v;
  endfunction

  // rebuild the table for one range write; returns the status code
  function automatic logic [1:0] apply_range(logic signed [15:0] kb, logic signed [15:0] ke,
                                             logic [7:0] val);
    logic signed [15:0] wk[ENTRIES+2];
    logic [7:0]         wv[ENTRIES+2];
    logic [7:0]         end_val, prev;
    int                 n, m;
    bit                 placed;
    n = 0; m = 0; placed = 0;
    if (!(kb < ke)) return STAT_EMPTY;
    end_val = value_at_key(ke);
    for (int i = 0; i < bp_count; i++) begin
      if (bp_key[i] < kb) begin
        wk[n] = bp_key[i]; wv[n] = bp_val[i]; n++;
      end else begin
        if (!placed) begin
          wk[n] = kb; wv[n] = val; n++;
          wk[n] = ke; wv[n] = end_val; n++;
          placed = 1;
        end
        if (bp_key[i] > ke) begin
          wk[n] = bp_key[i]; wv[n] = bp_val[i]; n++;
        end
      end
    end
    if (!placed) begin
      wk[n] = kb; wv[n] = val; n++;
      wk[n] = ke; wv[n] = end_val; n++;
    end
    // drop breakpoints that repeat the value below them
    prev = init_val;
    for (int i = 0; i < n; i++) begin
      if (wv[i] != prev) begin
        wk[m] = wk[i]; wv[m] = wv[i]; m++;
        prev = wv[i];
      end
    end
    if (m > ENTRIES) return STAT_FULL;
    for (int i = 0; i < m; i++) begin
      bp_key[i] = wk[i]; bp_val[i] = wv[i];
    end
    bp_count = m;
    return STAT_ASSIGN;
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t p;
    if (r.kind == REQ_LOOKUP) begin
      p.rd = value_at_key(r.lk);
      p.st = STAT_LOOKUP;
    end else begin
      p.rd = '0;
      p.st = apply_range(r.kb, r.ke, r.val);
      if (p.st == STAT_ASSIGN) n_assign++;
      else if (p.st == STAT_FULL) n_full++;
      else n_empty++;
    end
    return p;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // driver: predicts on each transfer, then presents the head of the queue
  always @(posedge clk) begin
    req_t nx;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_rsps.push_back(predict_rsp({in_tuser, in_tdata[15:0], in_tdata[31:16],
                                             in_tdata[39:32], in_tdata[55:40]}));
        void'(pending_reqs.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nx = pending_reqs[0];
          in_tvalid <= 1'b1;
          in_tuser  <= nx.kind;
          in_tdata  <= {nx.lk, nx.val, nx.ke, nx.kb};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result transfer with the oldest expectation
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        rsp_seen++;
        if (expected_rsps.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = expected_rsps.pop_front();
          if (out_tuser !== e.st)
            report_mismatch($sformatf("status %0d, expected %0d", out_tuser, e.st));
          if (out_tdata !== e.rd)
            report_mismatch($sformatf("read_value %0d, expected %0d", out_tdata, e.rd));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_assign(int kb, int ke, int v);
    req_t r;
    r.kind = REQ_ASSIGN; r.kb = 16'(kb); r.ke = 16'(ke); r.val = 8'(v);
    r.lk = 16'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic add_lookup(int k);
    req_t r;
    r.kind = REQ_LOOKUP; r.kb = 16'($urandom); r.ke = 16'($urandom);
    r.val = 8'($urandom); r.lk = 16'(k);
    pending_reqs.push_back(r);
  endtask

  // keys mostly from a narrow window so ranges overlap and the table fills
  function automatic int pick_key();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $signed(16'($urandom));
    if (sel == 1) return ($urandom_range(1) ? 32767 - $urandom_range(3) : -32768 +
                          $urandom_range(3));
    return $urandom_range(200) - 100;
  endfunction

  task automatic wait_drain();
    while (pending_reqs.size() > 0 || in_tvalid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_init(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    init_val = v;
    cfg_valid <= 1'b0;
  endtask

  // random phase: mostly overlapping writes, a share of lookups
  task automatic random_phase(int count, int idle, int stall);
    int a, b;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 6) begin
        a = pick_key(); b = pick_key();
        if ($urandom_range(9) < 8 && a > b) begin
          int t;
          t = a; a = b; b = t;
        end
        add_assign(a, b, $urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(3));
      end else begin
        add_lookup(pick_key());
      end
    end
    wait_drain();
  endtask

  initial begin
    bp_count = 0; init_val = '0; err_count = 0; rsp_seen = 0;
    n_assign = 0; n_full = 0; n_empty = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, empty ranges, merging, lookups of the initial value
    write_init(8'hFF);
    add_lookup(-32768);
    add_lookup(32767);
    add_assign(-32768, 32767, 8'h00);
    add_lookup(-32768);
    add_lookup(32766);
    add_lookup(32767);
    add_assign(5, 5, 8'h12);
    add_assign(10, -10, 8'h12);
    add_assign(32767, -32768, 8'hAA);
    add_assign(-5, 5, 8'hFF);
    add_assign(0, 3, 8'h55);
    add_assign(-5, 5, 8'h00);
    add_lookup(0);
    add_assign(-32768, -32767, 8'hAA);
    add_assign(32766, 32767, 8'h55);
    add_lookup(-1);
    add_lookup(32766);
    for (int i = 0; i < 18; i++) add_assign(2 * i, 2 * i + 1, 8'h01 + i);
    wait_drain();

    // a changed initial value is merged on the next write
    write_init(8'h00);
    add_lookup(-32768);
    add_assign(100, 200, 8'h00);
    add_lookup(150);
    wait_drain();

    random_phase(200, 0, 0);
    write_init(8'h80);
    random_phase(200, 63, 0);
    write_init(8'h02);
    random_phase(200, 0, 63);
    write_init(8'h01);
    random_phase(200, 14, 14);

    $display("Covered %0d results: %0d writes applied, %0d rejected as full, %0d empty.",
             rsp_seen, n_assign, n_full, n_empty);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/ivm_pkg.sv
hdl/ivm_table.sv
hdl/interval_value_map.sv
sim/tb_interval_value_map.sv
